[rtl/npt_pkg.sv]
`timescale 1ns / 1ps
// Package for the nearest point table: request and status codes, fixed field
// widths, the sequencer state type and the status struct of the distance unit.
// No dependencies.
package npt_pkg;

    // Fixed widths of the item fields.
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int IDX_OUT_W   = 6;
    localparam int COORD_OUT_W = 16;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_INSERT  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_NEAREST = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MEMBER  = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    // Status of the distance pipeline.
    typedef struct packed {
        logic out_valid;
        logic busy;
    } t_unit_stat;

endpackage

[rtl/npt_dist_unit.sv]
`timescale 1ns / 1ps
// Pipelined squared-distance unit of the nearest point table: one stored point
// enters per cycle, and its squared distance to the query leaves the sum register.
// Depends on npt_pkg.
module npt_dist_unit #(
    parameter int COORD_BITS = 16,
    parameter int IDX_W      = 6
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [IDX_W-1:0]        i_idx,
    input  logic [COORD_BITS-1:0]   i_qx,
    input  logic [COORD_BITS-1:0]   i_qy,
    input  logic [COORD_BITS-1:0]   i_px,
    input  logic [COORD_BITS-1:0]   i_py,
    output npt_pkg::t_unit_stat     o_stat,
    output logic [2*COORD_BITS:0]   o_dist,
    output logic [IDX_W-1:0]        o_idx,
    output logic [COORD_BITS-1:0]   o_px,
    output logic [COORD_BITS-1:0]   o_py
);

    localparam int SQ_W = 2 * COORD_BITS;
    localparam int D_W  = 2 * COORD_BITS + 1;

    logic                  r_v1, r_v2, r_v3;
    logic [COORD_BITS-1:0] r_dx, r_dy;
    logic [SQ_W-1:0]       r_sq_x, r_sq_y;
    logic [D_W-1:0]        r_dist;
    logic [IDX_W-1:0]      r_idx1, r_idx2, r_idx3;
    logic [COORD_BITS-1:0] r_px1, r_px2, r_px3;
    logic [COORD_BITS-1:0] r_py1, r_py2, r_py3;

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Stage one takes the absolute differences, stage two squares them,
    // and stage three adds the squares.
    always_ff @(posedge i_clk) begin
        r_dx   <= (i_qx > i_px) ? (i_qx - i_px) : (i_px - i_qx);
        r_dy   <= (i_qy > i_py) ? (i_qy - i_py) : (i_py - i_qy);
        r_idx1 <= i_idx;
        r_px1  <= i_px;
        r_py1  <= i_py;

        r_sq_x <= SQ_W'(r_dx) * SQ_W'(r_dx);
        r_sq_y <= SQ_W'(r_dy) * SQ_W'(r_dy);
        r_idx2 <= r_idx1;
        r_px2  <= r_px1;
        r_py2  <= r_py1;

        r_dist <= D_W'(r_sq_x) + D_W'(r_sq_y);
        r_idx3 <= r_idx2;
        r_px3  <= r_px2;
        r_py3  <= r_py2;
    end

    assign o_stat.out_valid = r_v3;
    assign o_stat.busy      = r_v1 | r_v2 | r_v3;
    assign o_dist           = r_dist;
    assign o_idx            = r_idx3;
    assign o_px             = r_px3;
    assign o_py             = r_py3;

endmodule

[rtl/nearest_point_table_top.sv]
`timescale 1ns / 1ps
// Nearest point table, top level: point memory, scan sequencer and result register.
// Depends on npt_pkg and npt_dist_unit.
//
// The block stores up to MAX_POINTS two-dimensional points and answers inserts,
// nearest-point queries and membership queries, one result item per request item.
// Every insert, nearest or member request on a non-empty table scans the stored
// points in index order, one memory read per cycle, through a three-stage
// squared-distance pipeline. The result is loaded from the done state after the
// scan and drain states, and the next item can be accepted once it is loaded. A
// request on an empty table and an unused request code go straight to the done
// state and load their result there without a scan. The single read port of the
// point memory sets the scan rate. Input stall is high from acceptance until the
// result has been loaded into the output register, so a stalled output register
// holds off the next item; a finished result may wait there while the next item is
// accepted. The point memory needs no clearing.
module nearest_point_table_top #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [npt_pkg::REQ_W-1:0]           i_req_type,
    input  logic [npt_pkg::COORD_OUT_W-1:0]     i_x_coord,
    input  logic [npt_pkg::COORD_OUT_W-1:0]     i_y_coord,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [npt_pkg::STATUS_W-1:0]        o_status,
    output logic [npt_pkg::IDX_OUT_W-1:0]       o_entry_index,
    output logic [npt_pkg::COORD_OUT_W-1:0]     o_near_x,
    output logic [npt_pkg::COORD_OUT_W-1:0]     o_near_y,
    output logic                                o_is_member
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int D_W   = 2 * COORD_BITS + 1;
    localparam int CW    = npt_pkg::COORD_OUT_W;
    localparam int IW    = npt_pkg::IDX_OUT_W;

    npt_pkg::t_state r_state, n_state;

    logic                          in_accept;
    logic [CW+COORD_BITS-1:0]      ext_in_x, ext_in_y;

    logic [npt_pkg::REQ_W-1:0]     r_req;
    logic [COORD_BITS-1:0]         r_qx, r_qy;
    logic [CNT_W-1:0]              r_count;
    logic [IDX_W-1:0]              r_addr;
    logic                          last_addr;

    logic [2*COORD_BITS-1:0]       r_point_mem [MAX_POINTS];
    logic [2*COORD_BITS-1:0]       r_rd_data;
    logic                          r_rd_valid;
    logic [IDX_W-1:0]              r_rd_idx;

    npt_pkg::t_unit_stat           u_stat;
    logic [D_W-1:0]                u_dist;
    logic [IDX_W-1:0]              u_idx;
    logic [COORD_BITS-1:0]         u_px, u_py;

    logic                          r_have_best;
    logic [D_W-1:0]                r_best_d;
    logic [IDX_W-1:0]              r_best_idx;
    logic [COORD_BITS-1:0]         r_best_x, r_best_y;

    logic                          scan_issue;
    logic                          load_out;
    logic                          out_free;
    logic                          is_match;
    logic                          table_full;
    logic                          do_write;

    logic [npt_pkg::STATUS_W-1:0]  res_status;
    logic [IDX_W-1:0]              res_idx;
    logic [COORD_BITS-1:0]         res_x, res_y;
    logic                          res_member;
    logic [IW+IDX_W-1:0]           ext_idx;
    logic [CW+COORD_BITS-1:0]      ext_x, ext_y;

    logic                          r_out_valid;
    logic [npt_pkg::STATUS_W-1:0]  r_status;
    logic [IW-1:0]                 r_entry_index;
    logic [CW-1:0]                 r_near_x, r_near_y;
    logic                          r_is_member;

    // Input handshake and coordinate masking to COORD_BITS.
    assign o_in_stall = (r_state != npt_pkg::S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign ext_in_x   = {{COORD_BITS{1'b0}}, i_x_coord};
    assign ext_in_y   = {{COORD_BITS{1'b0}}, i_y_coord};

    // The scan ends when the address reaches the last stored entry.
    assign last_addr  = ((CNT_W'(r_addr) + CNT_W'(1)) == r_count);
    assign out_free   = !r_out_valid || !i_out_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            npt_pkg::S_IDLE: begin
                if (in_accept) begin
                    if (i_req_type inside {npt_pkg::REQ_INSERT, npt_pkg::REQ_NEAREST,
                                           npt_pkg::REQ_MEMBER}) begin
                        n_state = (r_count == '0) ? npt_pkg::S_DONE : npt_pkg::S_SCAN;
                    end else begin
                        n_state = npt_pkg::S_DONE;
                    end
                end
            end
            npt_pkg::S_SCAN: begin
                if (last_addr) begin
                    n_state = npt_pkg::S_DRAIN;
                end
            end
            npt_pkg::S_DRAIN: begin
                if (!r_rd_valid && !u_stat.busy) begin
                    n_state = npt_pkg::S_DONE;
                end
            end
            npt_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = npt_pkg::S_IDLE;
                end
            end
            default: n_state = npt_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        scan_issue = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            npt_pkg::S_SCAN: scan_issue = 1'b1;
            npt_pkg::S_DONE: load_out   = out_free;
            default: begin
                scan_issue = 1'b0;
                load_out   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= npt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Latch the request and run the scan address.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req <= i_req_type;
            r_qx  <= ext_in_x[COORD_BITS-1:0];
            r_qy  <= ext_in_y[COORD_BITS-1:0];
        end
        if (in_accept) begin
            r_addr <= '0;
        end else if (scan_issue) begin
            r_addr <= r_addr + IDX_W'(1);
        end
    end

    // Point memory: one write for an insert, one registered read per scan cycle.
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_point_mem[r_count[IDX_W-1:0]] <= {r_qx, r_qy};
        end
        r_rd_data <= r_point_mem[r_addr];
        r_rd_idx  <= r_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= scan_issue;
        end
    end

    npt_dist_unit #(
        .COORD_BITS (COORD_BITS),
        .IDX_W      (IDX_W)
    ) u_dist_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rd_valid),
        .i_idx   (r_rd_idx),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .i_px    (r_rd_data[2*COORD_BITS-1:COORD_BITS]),
        .i_py    (r_rd_data[COORD_BITS-1:0]),
        .o_stat  (u_stat),
        .o_dist  (u_dist),
        .o_idx   (u_idx),
        .o_px    (u_px),
        .o_py    (u_py)
    );

    // Keep the best entry so far; a strict compare lets the lowest index win a tie.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_best <= 1'b0;
        end else if (in_accept) begin
            r_have_best <= 1'b0;
        end else if (u_stat.out_valid) begin
            r_have_best <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (u_stat.out_valid && (!r_have_best || u_dist < r_best_d)) begin
            r_best_d   <= u_dist;
            r_best_idx <= u_idx;
            r_best_x   <= u_px;
            r_best_y   <= u_py;
        end
    end

    // Result of the finished request.
    assign is_match   = r_have_best && (r_best_d == '0);
    assign table_full = (r_count == CNT_W'(MAX_POINTS));

    always_comb begin
        res_status = npt_pkg::ST_OK;
        res_idx    = '0;
        res_x      = '0;
        res_y      = '0;
        res_member = 1'b0;
        do_write   = 1'b0;
        case (r_req)
            npt_pkg::REQ_INSERT: begin
                if (is_match) begin
                    res_status = npt_pkg::ST_DUP;
                    res_idx    = r_best_idx;
                    res_x      = r_best_x;
                    res_y      = r_best_y;
                    res_member = 1'b1;
                end else if (table_full) begin
                    res_status = npt_pkg::ST_FULL;
                end else begin
                    res_idx  = r_count[IDX_W-1:0];
                    res_x    = r_qx;
                    res_y    = r_qy;
                    do_write = load_out;
                end
            end
            npt_pkg::REQ_NEAREST: begin
                if (r_count == '0) begin
                    res_status = npt_pkg::ST_EMPTY;
                end else begin
                    res_idx    = r_best_idx;
                    res_x      = r_best_x;
                    res_y      = r_best_y;
                    res_member = is_match;
                end
            end
            npt_pkg::REQ_MEMBER: begin
                if (r_count == '0) begin
                    res_status = npt_pkg::ST_EMPTY;
                end else if (is_match) begin
                    res_idx    = r_best_idx;
                    res_x      = r_best_x;
                    res_y      = r_best_y;
                    res_member = 1'b1;
                end
            end
            default: begin
                res_status = npt_pkg::ST_OK;
            end
        endcase
    end

    // Stored point count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (do_write) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // Output register.
    assign ext_idx = {{IW{1'b0}}, res_idx};
    assign ext_x   = {{CW{1'b0}}, res_x};
    assign ext_y   = {{CW{1'b0}}, res_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_status      <= res_status;
            r_entry_index <= ext_idx[IW-1:0];
            r_near_x      <= ext_x[CW-1:0];
            r_near_y      <= ext_y[CW-1:0];
            r_is_member   <= res_member;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_index = r_entry_index;
    assign o_near_x      = r_near_x;
    assign o_near_y      = r_near_y;
    assign o_is_member   = r_is_member;

    // The point count only ever steps up by one, and only as a result is loaded.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> ((r_count == $past(r_count) + CNT_W'(1))
            && r_out_valid))
        else $error("point count changed outside an insert");

    // Distances leave the pipeline only while a scan is in progress.
    a_scan_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        u_stat.out_valid |-> (r_state == npt_pkg::S_SCAN || r_state == npt_pkg::S_DRAIN))
        else $error("distance result outside a scan");

    // An empty status is given only for an empty table.
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && res_status == npt_pkg::ST_EMPTY) |-> (r_count == '0))
        else $error("empty status with stored points");

    // The count never exceeds the table size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_write |-> !table_full)
        else $error("write into a full table");

endmodule
